### hw/rtl/cdq_pkg.sv
// Shared types and constants for the circular deque.
// Used by cdq_cell, circular_deque, cdq_checker, cdq_scoreboard and the testbench. No dependencies.
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCC_W  = 5;

    // operation codes
    localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
    localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_BACK   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // commands broadcast to every cell
    typedef logic [2:0] cell_cmd_t;
    localparam cell_cmd_t CMD_HOLD   = 3'd0;
    localparam cell_cmd_t CMD_SHR    = 3'd1; // push front: everything moves toward the back
    localparam cell_cmd_t CMD_SHL    = 3'd2; // pop front: everything moves toward the front
    localparam cell_cmd_t CMD_APPEND = 3'd3; // push back: first free cell takes the word
    localparam cell_cmd_t CMD_DROP   = 3'd4; // pop back: last occupied cell empties

    typedef struct packed {
        cell_cmd_t           cmd;
        logic [DATA_W-1:0]   data;
    } cell_ctrl_t;

endpackage

### hw/rtl/circular_deque.sv
// Top level of the fixed-capacity deque: cell row, occupancy count and result register.
// Depends on cdq_pkg and cdq_cell.
//
// A deque of DEPTH 32-bit words kept as a row of cells, front at cell 0. Every
// transaction on the s_ channel yields exactly one registered result on the
// m_ channel: status, the word removed by a successful pop (zero otherwise) and
// the occupancy afterwards. Push at the front shifts the whole row back by one
// cell, pop at the front shifts it forward, while push and pop at the back touch
// only the cell at the boundary of the occupied region. The block takes one
// operation per clock; a new operation enters in the same cycle that the previous
// result leaves, so s_ready drops only while a held result is stalled by m_ready.
// A push into a full deque returns overflow and a pop from an empty one returns
// underflow, both leaving the contents untouched.
module circular_deque
    import cdq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_operation,
    input  logic signed [DATA_W-1:0] s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic signed [DATA_W-1:0] m_popped_value,
    output logic [OCC_W-1:0]         m_occupancy
);

    cell_ctrl_t        ctrl;
    logic              cell_valid [DEPTH];
    logic [DATA_W-1:0] cell_data  [DEPTH];
    logic [DATA_W-1:0] cell_tail  [DEPTH];
    logic [DATA_W-1:0] tail_word;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;

    logic accept;
    logic full;
    logic empty;

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic              lv, rv;
            logic [DATA_W-1:0] ld, rd;
            if (gi == 0) begin : g_head
                assign lv = 1'b1;
                assign ld = ctrl.data;
            end else begin : g_mid
                assign lv = cell_valid[gi-1];
                assign ld = cell_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_end
                assign rv = 1'b0;
                assign rd = '0;
            end else begin : g_nxt
                assign rv = cell_valid[gi+1];
                assign rd = cell_data[gi+1];
            end
            cdq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .left_valid  (lv),
                .left_data   (ld),
                .right_valid (rv),
                .right_data  (rd),
                .valid_o     (cell_valid[gi]),
                .data_o      (cell_data[gi]),
                .tail_data   (cell_tail[gi])
            );
        end
    endgenerate

    always_comb begin
        tail_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tail_word = tail_word | cell_tail[i];
        end
    end

    always_comb begin
        ctrl.cmd    = CMD_HOLD;
        ctrl.data   = s_data;
        status_next = ST_OK;
        value_next  = '0;
        count_next  = count_reg;
        if (s_operation inside {OP_PUSH_BACK, OP_PUSH_FRONT}) begin
            if (full) begin
                status_next = ST_OVERFLOW;
            end else begin
                ctrl.cmd   = (s_operation == OP_PUSH_BACK) ? CMD_APPEND : CMD_SHR;
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                status_next = ST_UNDERFLOW;
            end else if (s_operation == OP_POP_FRONT) begin
                ctrl.cmd   = CMD_SHL;
                value_next = cell_data[0];
                count_next = count_reg - CNT_W'(1);
            end else begin
                ctrl.cmd   = CMD_DROP;
                value_next = tail_word;
                count_next = count_reg - CNT_W'(1);
            end
        end
        if (!accept) begin
            ctrl.cmd   = CMD_HOLD;
            count_next = count_reg;
        end
        occ_next = OCC_W'(count_next);
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            value_reg  <= value_next;
            occ_reg    <= occ_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_popped_value = value_reg;
    assign m_occupancy    = occ_reg;

endmodule

### hw/rtl/cdq_cell.sv
// One slot of the deque cell row: an occupied flag and a data word.
// Depends on cdq_pkg.
module cdq_cell
    import cdq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl,
    input  logic              left_valid,
    input  logic [DATA_W-1:0] left_data,
    input  logic              right_valid,
    input  logic [DATA_W-1:0] right_data,
    output logic              valid_o,
    output logic [DATA_W-1:0] data_o,
    output logic [DATA_W-1:0] tail_data
);

    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              is_last;
    logic              is_first_free;

    assign is_last       = valid_reg & ~right_valid;
    assign is_first_free = ~valid_reg & left_valid;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (ctrl.cmd)
            CMD_SHR: begin
                valid_next = left_valid;
                data_next  = left_data;
            end
            CMD_SHL: begin
                valid_next = right_valid;
                data_next  = right_data;
            end
            CMD_APPEND: begin
                if (is_first_free) begin
                    valid_next = 1'b1;
                    data_next  = ctrl.data;
                end
            end
            CMD_DROP: begin
                if (is_last) begin
                    valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign valid_o   = valid_reg;
    assign data_o    = data_reg;
    // only the back cell drives its word onto the OR tree
    assign tail_data = is_last ? data_reg : '0;

endmodule

### hw/rtl/cdq_checker.sv
// Port-level checks for circular_deque, attached to the top level by bind.
// Depends on cdq_pkg.
module cdq_checker
    import cdq_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [1:0]               m_status,
    input logic signed [DATA_W-1:0] m_popped_value,
    input logic [OCC_W-1:0]         m_occupancy
);

    // held result must not change while the sink stalls
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_popped_value) && $stable(m_occupancy))
        else $error("result changed while stalled");

    // an empty result register always takes a transaction
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_popped_value == '0)
        else $error("failed operation returned a value");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OVERFLOW |-> m_occupancy == OCC_W'(DEPTH))
        else $error("overflow reported below capacity");

    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_UNDERFLOW |-> m_occupancy == '0)
        else $error("underflow reported while not empty");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_popped_value (m_popped_value),
    .m_occupancy    (m_occupancy)
);

### dv/cdq_checker.sv
// Scoreboard for the circular deque: watches both channels, predicts each result
// from a shadow deque and compares it field by field. Depends on cdq_pkg.
`timescale 1ns / 100ps

module cdq_scoreboard
    import cdq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [1:0]               s_operation,
    input  logic signed [DATA_W-1:0] s_data,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [1:0]               m_status,
    input  logic signed [DATA_W-1:0] m_popped_value,
    input  logic [OCC_W-1:0]         m_occupancy,
    output int                       fail_count,
    output int                       pending
);

    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value;
        logic [OCC_W-1:0]         occ;
    } deque_result_t;

    // shadow deque
    logic [DATA_W-1:0] shadow_store [DEPTH];
    int                front_idx = 0;
    int                back_idx  = 0;   // slot just past the back element
    int                held      = 0;

    // expected results in order of acceptance
    deque_result_t expected_mem [EXP_DEPTH];
    int            wr_cnt    = 0;
    int            rd_cnt    = 0;
    int            n_errors  = 0;
    int            n_results = 0;

    function automatic deque_result_t apply_op(logic [1:0] op, logic [DATA_W-1:0] word);
        deque_result_t r;
        r.status = ST_OK;
        r.value  = '0;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (held >= DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else if (op == OP_PUSH_BACK) begin
                    shadow_store[back_idx] = word;
                    back_idx = (back_idx + 1) % DEPTH;
                    held++;
                end else begin
                    front_idx = (front_idx + DEPTH - 1) % DEPTH;
                    shadow_store[front_idx] = word;
                    held++;
                end
            end
            default: begin
                if (held == 0) begin
                    r.status = ST_UNDERFLOW;
                end else if (op == OP_POP_FRONT) begin
                    r.value   = shadow_store[front_idx];
                    front_idx = (front_idx + 1) % DEPTH;
                    held--;
                end else begin
                    back_idx = (back_idx + DEPTH - 1) % DEPTH;
                    r.value  = shadow_store[back_idx];
                    held--;
                end
            end
        endcase
        r.occ = OCC_W'(held);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("%0t cdq_scoreboard: result %0d %s: got %h, expected %h",
                 $realtime, n_results, what, got, want);
        n_errors++;
    endtask

    always @(posedge aclk) begin
        deque_result_t want;
        if (!aresetn) begin
            front_idx = 0;
            back_idx  = 0;
            held      = 0;
            wr_cnt    = 0;
            rd_cnt    = 0;
        end else begin
            // results always trail their operation, so record the new one first
            if (s_valid && s_ready) begin
                expected_mem[wr_cnt % EXP_DEPTH] = apply_op(s_operation, s_data);
                wr_cnt++;
            end
            if (m_valid && m_ready) begin
                if (wr_cnt == rd_cnt) begin
                    report_mismatch("with no operation outstanding", m_status, '0);
                end else begin
                    want = expected_mem[rd_cnt % EXP_DEPTH];
                    rd_cnt++;
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_popped_value !== want.value)
                        report_mismatch("popped_value", m_popped_value, want.value);
                    if (m_occupancy !== want.occ)
                        report_mismatch("occupancy", m_occupancy, want.occ);
                end
                n_results++;
            end
        end
        fail_count <= n_errors;
        pending    <= wr_cnt - rd_cnt;
    end

endmodule

### dv/circular_deque_tb.sv
// Top of the circular deque testbench: clock, reset, operation stimulus, result-side
// stalls, watchdog and verdict. Depends on cdq_pkg, circular_deque and cdq_scoreboard.
`timescale 1ns / 100ps

module circular_deque_tb;
    import cdq_pkg::*;

    localparam int NUM_RANDOM     = 725;
    localparam int QUIET_TAIL     = 100;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_operation = OP_PUSH_BACK;
    logic signed [DATA_W-1:0] s_data      = '0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    logic [1:0]               m_status;
    logic signed [DATA_W-1:0] m_popped_value;
    logic [OCC_W-1:0]         m_occupancy;

    logic quiet = 1'b0;   // no idling on either side
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    int   rx_stall    = 0;

    always #2 aclk = ~aclk;

    circular_deque u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_popped_value (m_popped_value),
        .m_occupancy    (m_occupancy)
    );

    cdq_scoreboard u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_popped_value (m_popped_value),
        .m_occupancy    (m_occupancy),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // result-side stalls in bursts of random length
    always @(posedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall--;
        end else if ($urandom_range(0, 9) == 0) begin
            m_ready <= 1'b0;
            rx_stall = $urandom_range(0, 13);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** circular_deque: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_op(logic [1:0] op, logic [DATA_W-1:0] word);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_data      <= word;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int       i;
        int       phase_left;
        int       push_pct;
        logic [1:0] op;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // underflow at both ends, then single element in and out of each end
        send_op(OP_POP_FRONT, 32'h1234_5678);
        send_op(OP_POP_BACK, 32'hFFFF_FFFF);
        send_op(OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_op(OP_POP_BACK, '0);
        send_op(OP_PUSH_FRONT, 32'h8000_0000);  // front wraps below index 0
        send_op(OP_POP_FRONT, '0);
        // fill to capacity from both ends, then overflow on each push
        for (i = 0; i < DEPTH; i++)
            send_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, 32'h0000_0001 << (2 * i + i[0]));
        send_op(OP_PUSH_BACK, 32'hDEAD_BEEF);
        send_op(OP_PUSH_FRONT, 32'hCAFE_F00D);
        wait_all_results();

        // random walk that swings between filling and draining
        phase_left = 0;
        push_pct   = 50;
        for (i = 0; i < NUM_RANDOM; i++) begin
            if (i == NUM_RANDOM - QUIET_TAIL)
                quiet <= 1'b1;
            if (i == NUM_RANDOM / 2)
                wait_all_results();
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 50);
                case ($urandom_range(0, 2))
                    0:       push_pct = 80;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            phase_left--;
            if ($urandom_range(1, 100) <= push_pct)
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            send_op(op, pick_word());
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("** circular_deque: PASSED **");
        else
            $display("** circular_deque: FAILED **");
        $finish;
    end

endmodule

### circular_deque.f
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_cell.sv
hw/rtl/circular_deque.sv
hw/rtl/cdq_checker.sv
dv/cdq_checker.sv
dv/circular_deque_tb.sv
